// ----- rtl/rkte_pkg.sv -----
`default_nettype none
package rkte_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_OPS    = 3'd0,
    REG_MEM_BW      = 3'd1,
    REG_OVERHEAD    = 3'd2,
    REG_MP_COUNT    = 3'd3,
    REG_MAX_THREADS = 3'd4,
    REG_MAX_BLOCKS  = 3'd5
  } cfg_reg_t;

  // register reset values
  localparam logic [19:0] PEAK_OPS_RST    = 20'd10000;
  localparam logic [15:0] MEM_BW_RST      = 16'd900;
  localparam logic [31:0] OVERHEAD_RST    = 32'd1000000;
  localparam logic [9:0]  MP_COUNT_RST    = 10'd0;
  localparam logic [15:0] MAX_THREADS_RST = 16'd2048;
  localparam logic [7:0]  MAX_BLOCKS_RST  = 8'd32;

  // datapath widths
  localparam int THREADS_W = 43;   // blocks times threads per block
  localparam int PROD_W    = 76;   // threads times summed ops or bytes
  localparam int SCALED_W  = 86;   // the above times 1000
  localparam int CONC_W    = 18;   // concurrent block slots
  localparam int WAVE_W    = 33;   // waves, and waves times slots
  localparam int TOT_W     = 119;  // scaled term times wave product

  // x * 1000 as shifts: 1024 - 16 - 8
  function automatic logic [SCALED_W-1:0] times_1000(input logic [PROD_W-1:0] x);
    logic [SCALED_W-1:0] w;
    w = SCALED_W'(x);
    return (w << 10) - (w << 4) - (w << 3);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/roofline_kernel_time_estimate_top.sv -----
`default_nettype none
// Roofline kernel time estimate, fully pipelined.
// Input channel: one launch description word (block count, threads per block,
// op and byte counts per thread) is taken when in_valid is high and in_stall
// low. Output channel: one word per input (kernel_time_ps, saturated), taken
// when out_valid is high and out_stall low. Words leave in input order.
// Configuration: six registers written over cfg_valid/cfg_ready (ready is
// always high), index and data; write only while no word is in flight.
// The path runs through a 16-stage divider for blocks per SM, a 33-stage
// divider for the wave count, two parallel 86-stage dividers for the compute
// and memory terms, a 119-stage divider for the wave penalty, plus nine
// register stages of capture, multiply, add and select. Throughput is one
// word per cycle while the output word is not stalled.
// Reset (rst, synchronous) empties the pipeline and restores the register
// defaults. While the output word is stalled the whole pipeline holds, and
// in_stall is raised; no word is lost or repeated.
module roofline_kernel_time_estimate_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     block_count,
  input  logic [10:0]                     threads_per_block,
  input  logic [31:0]                     float_ops_each,
  input  logic [31:0]                     int_ops_each,
  input  logic [31:0]                     read_bytes_each,
  input  logic [31:0]                     written_bytes_each,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [63:0]                     kernel_time_ps,
  output logic                            saturated,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rkte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rkte_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rkte_pkg::*;

  // configuration registers
  logic [19:0] peak_ops_per_ns;
  logic [15:0] mem_bytes_per_ns;
  logic [31:0] launch_overhead_ps;
  logic [9:0]  mp_count;
  logic [15:0] max_threads_per_sm;
  logic [7:0]  max_blocks_per_sm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_ops_per_ns    <= PEAK_OPS_RST;
      mem_bytes_per_ns   <= MEM_BW_RST;
      launch_overhead_ps <= OVERHEAD_RST;
      mp_count           <= MP_COUNT_RST;
      max_threads_per_sm <= MAX_THREADS_RST;
      max_blocks_per_sm  <= MAX_BLOCKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PEAK_OPS:    peak_ops_per_ns    <= cfg_data[19:0];
        REG_MEM_BW:      mem_bytes_per_ns   <= cfg_data[15:0];
        REG_OVERHEAD:    launch_overhead_ps <= cfg_data[31:0];
        REG_MP_COUNT:    mp_count           <= cfg_data[9:0];
        REG_MAX_THREADS: max_threads_per_sm <= cfg_data[15:0];
        REG_MAX_BLOCKS:  max_blocks_per_sm  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless the output word is held
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage A: capture, sum ops and bytes
  logic        a_valid;
  logic [31:0] a_blocks;
  logic [10:0] a_tpb;
  logic [32:0] a_ops;
  logic [32:0] a_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_blocks <= block_count;
      a_tpb    <= threads_per_block;
      a_ops    <= {1'b0, float_ops_each} + {1'b0, int_ops_each};
      a_bytes  <= {1'b0, read_bytes_each} + {1'b0, written_bytes_each};
    end
  end

  // blocks per SM from the thread budget
  logic        bd_valid;
  logic [15:0] bd_q;
  logic [31:0] bd_blocks;
  logic [10:0] bd_tpb;
  logic [32:0] bd_ops;
  logic [32:0] bd_bytes;

  rkte_div #(.N(16), .D(11), .W(109)) u_div_bps (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(a_valid),
    .dividend(max_threads_per_sm),
    .divisor(a_tpb),
    .side_in({a_blocks, a_tpb, a_ops, a_bytes}),
    .out_valid(bd_valid),
    .quotient(bd_q),
    .side_out({bd_blocks, bd_tpb, bd_ops, bd_bytes})
  );

  // stage B: clamp blocks per SM, slots, thread count
  logic [7:0] bps_c;
  always_comb begin
    if (bd_q > {8'd0, max_blocks_per_sm}) begin
      bps_c = max_blocks_per_sm;
    end else begin
      bps_c = bd_q[7:0];
    end
    if (bps_c == 8'd0) begin
      bps_c = 8'd1;
    end
  end

  logic                 b_valid;
  logic [31:0]          b_blocks;
  logic [32:0]          b_ops;
  logic [32:0]          b_bytes;
  logic [CONC_W-1:0]    b_conc;
  logic [THREADS_W-1:0] b_threads;
  logic                 b_skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= bd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_blocks  <= bd_blocks;
      b_ops     <= bd_ops;
      b_bytes   <= bd_bytes;
      b_conc    <= CONC_W'(mp_count) * CONC_W'(bps_c);
      b_threads <= THREADS_W'(bd_blocks) * THREADS_W'(bd_tpb);
      b_skip    <= (mp_count == 10'd0) || (bd_blocks == 32'd0) || (bd_tpb == 11'd0);
    end
  end

  // stage C: wave numerator, partial products of the totals
  logic              c_valid;
  logic [WAVE_W-1:0] c_wsum;
  logic [31:0]       c_blocks;
  logic [CONC_W-1:0] c_conc;
  logic              c_skip;
  logic [59:0]       c_op_lo;
  logic [58:0]       c_op_hi;
  logic [59:0]       c_by_lo;
  logic [58:0]       c_by_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_wsum   <= WAVE_W'(b_blocks) + WAVE_W'(b_conc) - WAVE_W'(1);
      c_blocks <= b_blocks;
      c_conc   <= b_conc;
      c_skip   <= b_skip;
      c_op_lo  <= 60'(b_threads) * 60'(b_ops[16:0]);
      c_op_hi  <= 59'(b_threads) * 59'(b_ops[32:17]);
      c_by_lo  <= 60'(b_threads) * 60'(b_bytes[16:0]);
      c_by_hi  <= 59'(b_threads) * 59'(b_bytes[32:17]);
    end
  end

  // wave count
  logic              wd_valid;
  logic [WAVE_W-1:0] wd_waves;
  logic [31:0]       wd_blocks;
  logic [CONC_W-1:0] wd_conc;
  logic              wd_skip;
  logic [59:0]       wd_op_lo;
  logic [58:0]       wd_op_hi;
  logic [59:0]       wd_by_lo;
  logic [58:0]       wd_by_hi;

  rkte_div #(.N(WAVE_W), .D(CONC_W), .W(289)) u_div_wave (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c_valid),
    .dividend(c_wsum),
    .divisor(c_conc),
    .side_in({c_blocks, c_conc, c_skip, c_op_lo, c_op_hi, c_by_lo, c_by_hi}),
    .out_valid(wd_valid),
    .quotient(wd_waves),
    .side_out({wd_blocks, wd_conc, wd_skip, wd_op_lo, wd_op_hi, wd_by_lo, wd_by_hi})
  );

  // stage D: totals, wave product; a skipped penalty becomes times one over one
  logic [50:0] wc_full;
  assign wc_full = 51'(wd_waves) * 51'(wd_conc);

  logic              d_valid;
  logic [PROD_W-1:0] d_ops_t;
  logic [PROD_W-1:0] d_bytes_t;
  logic [WAVE_W-1:0] d_wc;
  logic [31:0]       d_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= wd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ops_t   <= PROD_W'(wd_op_lo) + (PROD_W'(wd_op_hi) << 17);
      d_bytes_t <= PROD_W'(wd_by_lo) + (PROD_W'(wd_by_hi) << 17);
      d_wc      <= wd_skip ? WAVE_W'(1) : wc_full[WAVE_W-1:0];
      d_div     <= wd_skip ? 32'd1 : wd_blocks;
    end
  end

  // stage E: scale to picoseconds
  logic                e_valid;
  logic [SCALED_W-1:0] e_comp_num;
  logic [SCALED_W-1:0] e_mem_num;
  logic [WAVE_W-1:0]   e_wc;
  logic [31:0]         e_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_comp_num <= times_1000(d_ops_t);
      e_mem_num  <= times_1000(d_bytes_t);
      e_wc       <= d_wc;
      e_div      <= d_div;
    end
  end

  // compute and memory terms in parallel
  logic                cd_valid;
  logic [SCALED_W-1:0] cd_q;
  logic [WAVE_W-1:0]   cd_wc;
  logic [31:0]         cd_div;
  logic                cd_zero;
  logic                md_valid;
  logic [SCALED_W-1:0] md_q;
  logic                md_zero;

  rkte_div #(.N(SCALED_W), .D(20), .W(WAVE_W + 33)) u_div_comp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(e_valid),
    .dividend(e_comp_num),
    .divisor(peak_ops_per_ns),
    .side_in({e_wc, e_div, peak_ops_per_ns == 20'd0}),
    .out_valid(cd_valid),
    .quotient(cd_q),
    .side_out({cd_wc, cd_div, cd_zero})
  );

  rkte_div #(.N(SCALED_W), .D(20), .W(1)) u_div_mem (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(e_valid),
    .dividend(e_mem_num),
    .divisor({4'd0, mem_bytes_per_ns}),
    .side_in(mem_bytes_per_ns == 16'd0),
    .out_valid(md_valid),
    .quotient(md_q),
    .side_out(md_zero)
  );

  // stage F: the roofline, larger of the two terms
  logic [SCALED_W-1:0] comp_t;
  logic [SCALED_W-1:0] mem_t;
  assign comp_t = cd_zero ? '0 : cd_q;
  assign mem_t  = md_zero ? '0 : md_q;

  logic                f_valid;
  logic [SCALED_W-1:0] f_t;
  logic [WAVE_W-1:0]   f_wc;
  logic [31:0]         f_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= cd_valid && md_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_t   <= (comp_t < mem_t) ? mem_t : comp_t;
      f_wc  <= cd_wc;
      f_div <= cd_div;
    end
  end

  // stage G: partial products of term times wave product
  logic        g_valid;
  logic [61:0] g_p0;
  logic [61:0] g_p1;
  logic [60:0] g_p2;
  logic [31:0] g_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_p0  <= 62'(f_t[28:0]) * 62'(f_wc);
      g_p1  <= 62'(f_t[57:29]) * 62'(f_wc);
      g_p2  <= 61'(f_t[85:58]) * 61'(f_wc);
      g_div <= f_div;
    end
  end

  // stage H: sum partials
  logic             h_valid;
  logic [TOT_W-1:0] h_num;
  logic [31:0]      h_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_num <= TOT_W'(g_p0) + (TOT_W'(g_p1) << 29) + (TOT_W'(g_p2) << 58);
      h_div <= g_div;
    end
  end

  // wave penalty division, overhead sampled with the word
  logic             fd_valid;
  logic [TOT_W-1:0] fd_q;
  logic [31:0]      fd_ovh;

  rkte_div #(.N(TOT_W), .D(32), .W(32)) u_div_fin (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(h_valid),
    .dividend(h_num),
    .divisor(h_div),
    .side_in(launch_overhead_ps),
    .out_valid(fd_valid),
    .quotient(fd_q),
    .side_out(fd_ovh)
  );

  // output register: add overhead, saturate
  logic [TOT_W:0] total;
  logic           over;
  assign total = (TOT_W + 1)'(fd_q) + (TOT_W + 1)'(fd_ovh);
  assign over  = |total[TOT_W:64];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kernel_time_ps <= over ? {64{1'b1}} : total[63:0];
      saturated      <= over;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rkte_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per stage, side word carried alongside
module rkte_div #(
  parameter int N = 16,
  parameter int D = 11,
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  input  logic [W-1:0] side_in,
  output logic         out_valid,
  output logic [N-1:0] quotient,
  output logic [W-1:0] side_out
);

  logic         vld [N];
  logic [D-1:0] rem [N];
  logic [N-1:0] acc [N];   // dividend bits shift out, quotient bits shift in
  logic [D-1:0] dvs [N];
  logic [W-1:0] sd  [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic         p_v;
    logic [D-1:0] p_rem;
    logic [D-1:0] p_dvs;
    logic [N-1:0] p_acc;
    logic [W-1:0] p_sd;
    logic [D:0]   trial;
    logic [D:0]   diff;
    logic         take;

    if (s == 0) begin : g_first
      assign p_v   = in_valid;
      assign p_rem = '0;
      assign p_dvs = divisor;
      assign p_acc = dividend;
      assign p_sd  = side_in;
    end else begin : g_next
      assign p_v   = vld[s-1];
      assign p_rem = rem[s-1];
      assign p_dvs = dvs[s-1];
      assign p_acc = acc[s-1];
      assign p_sd  = sd[s-1];
    end

    // trial subtract of the next dividend bit
    assign trial = {p_rem, p_acc[N-1]};
    assign take  = (trial >= {1'b0, p_dvs});
    assign diff  = trial - {1'b0, p_dvs};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= take ? diff[D-1:0] : trial[D-1:0];
        acc[s] <= {p_acc[N-2:0], take};
        dvs[s] <= p_dvs;
        sd[s]  <= p_sd;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quotient  = acc[N-1];
  assign side_out  = sd[N-1];

endmodule
`default_nettype wire

// ----- verif/roofline_kernel_time_estimate_top_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module roofline_kernel_time_estimate_top_tb;
  import rkte_pkg::*;

  localparam int LATENCY = 263;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] block_count = '0;
  logic [10:0] threads_per_block = '0;
  logic [31:0] float_ops_each = '0;
  logic [31:0] int_ops_each = '0;
  logic [31:0] read_bytes_each = '0;
  logic [31:0] written_bytes_each = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] kernel_time_ps;
  logic        saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the configuration registers
  logic [19:0] peak_ops;
  logic [15:0] mem_bw;
  logic [31:0] overhead;
  logic [9:0]  sm_cnt;
  logic [15:0] max_threads;
  logic [7:0]  max_blocks;

  typedef struct packed {
    logic [63:0] time_ps;
    logic        sat;
  } estimate_t;

  estimate_t est_q[$];
  int unsigned errors = 0;
  int unsigned words_checked = 0;
  int unsigned sat_seen = 0;
  bit stall_free = 1'b0;

  roofline_kernel_time_estimate_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("roofline_kernel_time_estimate_top_tb failed");
    $finish;
  end

  // gap length: mostly short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // estimated kernel time for one launch, from the shadow registers
  function automatic estimate_t estimate_time(logic [31:0] blocks, logic [10:0] tpb,
                                              logic [31:0] fops, logic [31:0] iops,
                                              logic [31:0] rdb, logic [31:0] wrb);
    logic [127:0] threads, ops, bytes, comp, mem, t, conc, waves, per_sm;
    estimate_t e;
    threads = 128'(blocks) * 128'(tpb);
    ops     = 128'(fops) + 128'(iops);
    bytes   = 128'(rdb) + 128'(wrb);
    comp    = '0;
    mem     = '0;
    if (peak_ops != 0) comp = threads * ops * 1000 / 128'(peak_ops);
    if (mem_bw != 0) mem = threads * bytes * 1000 / 128'(mem_bw);
    t = (comp < mem) ? mem : comp;
    if (sm_cnt != 0 && blocks != 0 && tpb != 0) begin
      per_sm = 128'(max_threads) / 128'(tpb);
      if (per_sm > 128'(max_blocks)) per_sm = 128'(max_blocks);
      if (per_sm < 1) per_sm = 1;
      conc  = 128'(sm_cnt) * per_sm;
      waves = (128'(blocks) + conc - 1) / conc;
      t = t * (waves * conc) / 128'(blocks);
    end
    t = t + 128'(overhead);
    if (t[127:64] != 0) begin
      e.time_ps = '1;
      e.sat = 1'b1;
    end else begin
      e.time_ps = t[63:0];
      e.sat = 1'b0;
    end
    return e;
  endfunction

  // send one launch word and record its expected estimate
  task automatic send_launch(logic [31:0] blocks, logic [10:0] tpb, logic [31:0] fops,
                             logic [31:0] iops, logic [31:0] rdb, logic [31:0] wrb,
                             bit no_gap = 0);
    int unsigned g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid           <= 1'b1;
    block_count        <= blocks;
    threads_per_block  <= tpb;
    float_ops_each     <= fops;
    int_ops_each       <= iops;
    read_bytes_each    <= rdb;
    written_bytes_each <= wrb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    est_q.push_back(estimate_time(blocks, tpb, fops, iops, rdb, wrb));
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    drop_valid();
    while (est_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // one register write; the caller lowers cfg_valid after the last one
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unique case (idx)
      REG_PEAK_OPS:    peak_ops    = val[19:0];
      REG_MEM_BW:      mem_bw      = val[15:0];
      REG_OVERHEAD:    overhead    = val;
      REG_MP_COUNT:    sm_cnt      = val[9:0];
      REG_MAX_THREADS: max_threads = val[15:0];
      REG_MAX_BLOCKS:  max_blocks  = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [19:0] p, logic [15:0] m, logic [31:0] o,
                         logic [9:0] s, logic [15:0] mt, logic [7:0] mb);
    drain();
    write_reg(REG_PEAK_OPS, 32'(p));
    write_reg(REG_MEM_BW, 32'(m));
    write_reg(REG_OVERHEAD, o);
    write_reg(REG_MP_COUNT, 32'(s));
    write_reg(REG_MAX_THREADS, 32'(mt));
    write_reg(REG_MAX_BLOCKS, 32'(mb));
    cfg_valid <= 1'b0;
  endtask

  // random launch: mostly modest sizes, some full-range fields
  task automatic send_random_launch(bit no_gap = 0);
    logic [31:0] b, f, i, r, w;
    logic [10:0] t;
    if ($urandom_range(0, 3) == 0) begin
      b = $urandom(); f = $urandom(); i = $urandom(); r = $urandom(); w = $urandom();
    end else begin
      b = $urandom_range(0, 5000);
      f = $urandom_range(0, 100000); i = $urandom_range(0, 100000);
      r = $urandom_range(0, 4096);   w = $urandom_range(0, 4096);
    end
    case ($urandom_range(0, 9))
      0:       t = 11'($urandom());
      1:       t = 11'd0;
      2:       t = 11'd1024;
      default: t = 11'($urandom_range(1, 1024));
    endcase
    send_launch(b, t, f, i, r, w, no_gap);
  endtask

  // output side: random stall and in-order check
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (est_q.size() == 0) begin
          $error("unexpected result word: kernel_time_ps %0d", kernel_time_ps);
          errors++;
        end else begin
          estimate_t e;
          e = est_q.pop_front();
          words_checked++;
          if (e.sat) sat_seen++;
          if (kernel_time_ps !== e.time_ps) begin
            $error("kernel_time_ps expected %0d actual %0d", e.time_ps, kernel_time_ps);
            errors++;
          end
          if (saturated !== e.sat) begin
            $error("saturated expected %0b actual %0b", e.sat, saturated);
            errors++;
          end
        end
      end
      out_stall <= stall_free ? 1'b0 : ($urandom_range(0, 99) < 20);
    end
  end

  task automatic test_reset_defaults();
    peak_ops = PEAK_OPS_RST; mem_bw = MEM_BW_RST; overhead = OVERHEAD_RST;
    sm_cnt = MP_COUNT_RST; max_threads = MAX_THREADS_RST; max_blocks = MAX_BLOCKS_RST;
    send_launch(1000, 256, 100, 50, 16, 8);
    send_launch(0, 0, 0, 0, 0, 0);
    send_launch('1, 11'h7FF, '1, '1, '1, '1);
  endtask

  task automatic test_directed();
    set_all(20'd10000, 16'd900, 32'd1000, 10'd80, 16'd2048, 8'd32);
    send_launch(0, 256, 10, 10, 10, 10);        // no blocks: penalty skipped
    send_launch(100, 0, 10, 10, 10, 10);        // no threads
    send_launch(1, 1, 0, 0, 0, 0);              // only overhead
    send_launch(1, 1024, 1, 1, 1, 1);
    send_launch(2561, 1024, 7, 3, 40, 40);      // partial last wave
    send_launch(5000, 2047, 1, 0, 0, 1);        // threads above range
    send_launch('1, 1024, '1, '1, '1, '1);      // overflow
    send_launch(32'h5555_5555, 11'h2AA, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA, 32'h5555_5555);
    send_launch(32'hAAAA_AAAA, 11'h555, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h5555_5555, 32'hAAAA_AAAA);
    // zero rates, zero budget and cap, extreme registers
    set_all(20'd0, 16'd0, 32'hFFFF_FFFF, 10'h3FF, 16'd0, 8'd0);
    send_launch(12345, 100, 10, 10, 10, 10);
    send_launch('1, 11'h7FF, 1, 1, 1, 1);
    set_all(20'hFFFFF, 16'hFFFF, 32'd0, 10'd1, 16'hFFFF, 8'hFF);
    send_launch(300, 1, 1000, 1000, 1000, 1000);
    send_launch('1, 1024, '1, '1, '1, '1);
    set_all(20'd1, 16'd1, 32'd0, 10'd1, 16'd32, 8'd1);
    send_launch(7, 64, 3, 0, 0, 5);
    send_launch('1, 11'h7FF, '1, '1, '1, '1);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      set_all(20'($urandom_range(0, 20000)) | (ph == 5 ? 20'hFFFFF : 20'd0),
              16'($urandom_range(0, 2000)),
              (ph == 4) ? 32'hFFFF_FFFF : $urandom_range(0, 2000000),
              (ph == 0) ? 10'd0 : 10'($urandom_range(1, 1023)),
              16'($urandom()), 8'($urandom()));
      for (int n = 0; n < 260; n++) send_random_launch();
    end
  endtask

  task automatic test_back_to_back();
    set_all(20'd10000, 16'd900, 32'd1000000, 10'd108, 16'd2048, 8'd32);
    stall_free = 1'b1;
    for (int n = 0; n < 60; n++) send_random_launch(1);
    stall_free = 1'b0;
    // hold off until every result is in, then resume
    drop_valid();
    while (est_q.size() != 0) @(posedge clk);
    for (int n = 0; n < 60; n++) send_random_launch(1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_phases();
    test_back_to_back();
    drain();
    $display("Checked %0d estimate words (%0d saturated) over reset, directed,",
             words_checked, sat_seen);
    $display("six random register settings and a back-to-back burst.");
    if (errors == 0 && est_q.size() == 0) begin
      $display("roofline_kernel_time_estimate_top_tb passed");
    end else begin
      $display("roofline_kernel_time_estimate_top_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
